FILE: rtl/touch_swipe_tap_classifier_core_assert.svh
// Assertion macros used by the checker file of the touch classifier.
`ifndef TOUCH_SWIPE_TAP_CLASSIFIER_CORE_ASSERT_SVH
`define TOUCH_SWIPE_TAP_CLASSIFIER_CORE_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted.
`define TSTC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TSTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tstc_pkg.sv
// Types and constants of the touch swipe and tap classifier.
package tstc_pkg;

    localparam int TS_W      = 48;
    localparam int COORD_W   = 10;
    localparam int DIST_W    = 10;
    localparam int LIM_W     = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;
    localparam int ACT_W     = 3;

    typedef enum logic [OP_W-1:0] {
        OP_BEGIN = 2'd0,
        OP_MOVE  = 2'd1,
        OP_END   = 2'd2
    } opcode_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE          = 3'd0,
        ACT_NEXT          = 3'd1,
        ACT_PREVIOUS      = 3'd2,
        ACT_PAGE_NEXT     = 3'd3,
        ACT_PAGE_PREVIOUS = 3'd4,
        ACT_TAP           = 3'd5
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SWIPE_MIN     = 2'd0,
        REG_GESTURE_LIMIT = 2'd1,
        REG_TAP_LIMIT     = 2'd2,
        REG_TAP_SLOP      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [DIST_W-1:0] swipe_min;
        logic [LIM_W-1:0]  gesture_limit;
        logic [LIM_W-1:0]  tap_limit;
        logic [DIST_W-1:0] tap_slop;
    } cfg_t;

    localparam logic [DIST_W-1:0] SWIPE_MIN_RST     = 10'd55;
    localparam logic [LIM_W-1:0]  GESTURE_LIMIT_RST = 24'd1500000;
    localparam logic [LIM_W-1:0]  TAP_LIMIT_RST     = 24'd500000;
    localparam logic [DIST_W-1:0] TAP_SLOP_RST      = 10'd16;

endpackage

FILE: rtl/touch_swipe_tap_classifier_core.sv
// Touch swipe and tap classifier top level. Takes one begin, move or end
// event per clock cycle unless stalled; every end event yields one action
// beat from the result register, while begin, move and unused opcodes yield
// nothing. One register stage holds the event and one the result, with the
// contact state updated between them; the input stalls only while an end
// event waits for the result register to drain. Only the low TIME_BITS bits
// of the timestamp (at most 48) take part in timing.
module touch_swipe_tap_classifier_core
    import tstc_pkg::*;
#(
    parameter int TIME_BITS = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      opcode,
    input  logic [COORD_W-1:0]   touch_x,
    input  logic [COORD_W-1:0]   touch_y,
    input  logic [TS_W-1:0]      timestamp,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ACT_W-1:0]     action
);

    localparam int TW = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;

    cfg_t               cfg;
    logic               advance;
    logic               s1_valid;
    logic [OP_W-1:0]    s1_opcode;
    logic [COORD_W-1:0] s1_x;
    logic [COORD_W-1:0] s1_y;
    logic [TW-1:0]      s1_time;

    tstc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tstc_in_reg #(
        .TW (TW)
    ) u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .touch_x   (touch_x),
        .touch_y   (touch_y),
        .timestamp (timestamp[TW-1:0]),
        .advance   (advance),
        .s1_valid  (s1_valid),
        .s1_opcode (s1_opcode),
        .s1_x      (s1_x),
        .s1_y      (s1_y),
        .s1_time   (s1_time)
    );

    tstc_engine #(
        .TW (TW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s1_valid  (s1_valid),
        .s1_opcode (s1_opcode),
        .s1_x      (s1_x),
        .s1_y      (s1_y),
        .s1_time   (s1_time),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .action    (action)
    );

endmodule

FILE: rtl/tstc_cfg_regs.sv
// Configuration register file of the touch classifier.
module tstc_cfg_regs
    import tstc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_SWIPE_MIN:     cfg_next.swipe_min     = cfg_wdata[DIST_W-1:0];
                REG_GESTURE_LIMIT: cfg_next.gesture_limit = cfg_wdata[LIM_W-1:0];
                REG_TAP_LIMIT:     cfg_next.tap_limit     = cfg_wdata[LIM_W-1:0];
                REG_TAP_SLOP:      cfg_next.tap_slop      = cfg_wdata[DIST_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.swipe_min     <= SWIPE_MIN_RST;
            cfg_reg.gesture_limit <= GESTURE_LIMIT_RST;
            cfg_reg.tap_limit     <= TAP_LIMIT_RST;
            cfg_reg.tap_slop      <= TAP_SLOP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/tstc_in_reg.sv
// Input register of the touch classifier: holds one event beat.
module tstc_in_reg
    import tstc_pkg::*;
#(
    parameter int TW = 48
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [OP_W-1:0]    opcode,
    input  logic [COORD_W-1:0] touch_x,
    input  logic [COORD_W-1:0] touch_y,
    input  logic [TW-1:0]      timestamp,
    input  logic               advance,
    output logic               s1_valid,
    output logic [OP_W-1:0]    s1_opcode,
    output logic [COORD_W-1:0] s1_x,
    output logic [COORD_W-1:0] s1_y,
    output logic [TW-1:0]      s1_time
);

    logic               valid_reg;
    logic               valid_next;
    logic [OP_W-1:0]    opcode_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [TW-1:0]      time_reg;
    logic               load;

    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload holds no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            opcode_reg <= opcode;
            x_reg      <= touch_x;
            y_reg      <= touch_y;
            time_reg   <= timestamp;
        end
    end

    assign s1_valid  = valid_reg;
    assign s1_opcode = opcode_reg;
    assign s1_x      = x_reg;
    assign s1_y      = y_reg;
    assign s1_time   = time_reg;

endmodule

FILE: rtl/tstc_engine.sv
// Contact state, gesture classification and result register.
module tstc_engine
    import tstc_pkg::*;
#(
    parameter int TW = 48
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               s1_valid,
    input  logic [OP_W-1:0]    s1_opcode,
    input  logic [COORD_W-1:0] s1_x,
    input  logic [COORD_W-1:0] s1_y,
    input  logic [TW-1:0]      s1_time,
    output logic               advance,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [ACT_W-1:0]   action
);

    logic               active_reg,  active_next;
    logic [COORD_W-1:0] start_x_reg, start_x_next;
    logic [COORD_W-1:0] start_y_reg, start_y_next;
    logic [TW-1:0]      start_t_reg, start_t_next;
    logic [DIST_W-1:0]  dev_x_reg,   dev_x_next;
    logic [DIST_W-1:0]  dev_y_reg,   dev_y_next;
    logic               out_valid_reg, out_valid_next;
    action_t            action_reg,  action_next;

    logic               is_end;
    logic               fire;
    logic [DIST_W-1:0]  adx, ady;
    logic [DIST_W-1:0]  upd_dev_x, upd_dev_y;
    logic [12:0]        adx4, ady4, adx5, ady5;
    logic [TW-1:0]      elapsed;
    logic               backwards, too_long, tap_time_ok;
    logic               h_swipe, v_swipe, tap_ok;
    action_t            end_action;

    assign is_end  = (s1_opcode == OP_END);
    // only an end beat needs the result slot
    assign advance = !(is_end && out_valid_reg && out_stall);
    assign fire    = s1_valid && advance;

    always_comb
    begin
        adx = (s1_x >= start_x_reg) ? (s1_x - start_x_reg) : (start_x_reg - s1_x);
        ady = (s1_y >= start_y_reg) ? (s1_y - start_y_reg) : (start_y_reg - s1_y);
        upd_dev_x = (adx > dev_x_reg) ? adx : dev_x_reg;
        upd_dev_y = (ady > dev_y_reg) ? ady : dev_y_reg;

        adx4 = {1'b0, adx, 2'b00};
        ady4 = {1'b0, ady, 2'b00};
        adx5 = {3'b000, adx} + adx4;
        ady5 = {3'b000, ady} + ady4;

        backwards   = (s1_time < start_t_reg);
        elapsed     = s1_time - start_t_reg;
        too_long    = elapsed > {{(TW-LIM_W){1'b0}}, cfg.gesture_limit};
        tap_time_ok = elapsed <= {{(TW-LIM_W){1'b0}}, cfg.tap_limit};

        h_swipe = (adx >= cfg.swipe_min) && (adx4 > ady5);
        v_swipe = (ady >= cfg.swipe_min) && (ady4 > adx5);
        tap_ok  = tap_time_ok && (upd_dev_x <= cfg.tap_slop) && (upd_dev_y <= cfg.tap_slop);

        if (!active_reg || backwards || too_long)
            end_action = ACT_NONE;
        else if (h_swipe)
            end_action = (s1_x < start_x_reg) ? ACT_NEXT : ACT_PREVIOUS;
        else if (v_swipe)
            end_action = (s1_y < start_y_reg) ? ACT_PAGE_NEXT : ACT_PAGE_PREVIOUS;
        else if (tap_ok)
            end_action = ACT_TAP;
        else
            end_action = ACT_NONE;
    end

    always_comb
    begin
        active_next    = active_reg;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        start_t_next   = start_t_reg;
        dev_x_next     = dev_x_reg;
        dev_y_next     = dev_y_reg;
        action_next    = action_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (fire)
        begin
            case (s1_opcode)
                OP_BEGIN:
                begin
                    active_next  = 1'b1;
                    start_x_next = s1_x;
                    start_y_next = s1_y;
                    start_t_next = s1_time;
                    dev_x_next   = '0;
                    dev_y_next   = '0;
                end
                OP_MOVE:
                begin
                    if (active_reg)
                    begin
                        dev_x_next = upd_dev_x;
                        dev_y_next = upd_dev_y;
                    end
                end
                OP_END:
                begin
                    if (active_reg)
                    begin
                        active_next = 1'b0;
                        dev_x_next  = upd_dev_x;
                        dev_y_next  = upd_dev_y;
                    end
                    action_next    = end_action;
                    out_valid_next = 1'b1;
                end
                default:
                begin
                    // unused opcode leaves state alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            start_t_reg   <= '0;
            dev_x_reg     <= '0;
            dev_y_reg     <= '0;
            out_valid_reg <= 1'b0;
            action_reg    <= ACT_NONE;
        end
        else
        begin
            active_reg    <= active_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            start_t_reg   <= start_t_next;
            dev_x_reg     <= dev_x_next;
            dev_y_reg     <= dev_y_next;
            out_valid_reg <= out_valid_next;
            action_reg    <= action_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;

endmodule

FILE: rtl/tstc_checker.sv
// Port-level checker for the touch classifier, bound to the top level.
`include "touch_swipe_tap_classifier_core_assert.svh"

module tstc_checker
    import tstc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [OP_W-1:0]    opcode,
    input logic               out_valid,
    input logic               out_stall,
    input logic [ACT_W-1:0]   action
);

    // a stalled result beat keeps its value
    `TSTC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(action), "result beat changed while stalled")

    // input backs up only behind a stalled result
    `TSTC_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled with result path free")

    // a fresh result must trace back to an end beat accepted at the input
    `TSTC_ASSERT(a_result_source, clk, rst_n, $rose(out_valid) |-> $past(in_valid && !in_stall && opcode == OP_END, 2), "result without a matching end beat")

    `TSTC_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind touch_swipe_tap_classifier_core tstc_checker u_tstc_checker (.*);
